### hw/rtl/icf_pkg.sv
package icf_pkg;

  localparam int POINTER_DIGITS_DEF = 16;
  localparam int MAX_FIELD_DEF      = 63;
  localparam int MAX_PREC           = 60;
  localparam int OUT_LIMIT          = 63;

  localparam int FIELD_W   = 6;
  localparam int PREC_W    = 6;
  localparam int ARG_W     = 64;
  localparam int CHAR_W    = 8;
  localparam int SIZE_W    = 9;
  localparam int TOTAL_W   = 8;
  localparam int REMAIN_W  = 6;
  localparam int ND_W      = 5;
  localparam int CONV_W    = 6;

  // Digit store: 22 four-bit slots, enough for 64 bits in octal.
  localparam int OCT_DIGITS = 22;
  localparam int DEC_DIGITS = 20;
  localparam int HEX_DIGITS = 16;
  localparam int DIG_W      = 4 * OCT_DIGITS;
  localparam int BCD_W      = 4 * DEC_DIGITS;

  localparam int FLAG_LEFT  = 0;
  localparam int FLAG_PLUS  = 1;
  localparam int FLAG_SPACE = 2;
  localparam int FLAG_ALT   = 3;
  localparam int FLAG_ZERO  = 4;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PCT   = 8'h25;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;

  typedef enum logic [2:0] {
    KIND_DEC, KIND_UNS, KIND_OCT, KIND_HEX, KIND_UHEX, KIND_PTR, KIND_CHR, KIND_PCT
  } icf_kind_t;

  typedef enum logic [1:0] {
    LEN_INT, LEN_SHORT, LEN_LONG, LEN_RSVD
  } icf_len_t;

  typedef enum logic [2:0] {
    SRC_LEAD, SRC_SIGN, SRC_PFX0, SRC_PFX1, SRC_ZPAD, SRC_PZERO, SRC_DIG, SRC_TRAIL
  } icf_src_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CONV, ST_NORM, ST_LAYOUT,
    ST_LEAD, ST_SIGN, ST_PFX0, ST_PFX1, ST_ZPAD, ST_PZERO, ST_DIG, ST_TRAIL
  } icf_state_t;

  typedef struct packed {
    logic     load;
    logic     conv_step;
    logic     norm_step;
    logic     layout;
    logic     emit;
    icf_src_t src;
  } icf_cmd_t;

  typedef struct packed {
    logic       is_dec;
    logic       skip_digits;
    logic       conv_last;
    logic       norm_done;
    logic       lead_zero;
    logic       has_sign;
    logic [1:0] pfx_len;
    logic       zpad_zero;
    logic       zcnt_zero;
    logic       nd_zero;
    logic       trail_zero;
    logic       remain_last;
    logic       out_free;
  } icf_sts_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CHAR_W-1:0] res;
    if (d < 4'd10) begin
      res = CH_ZERO + {4'b0, d};
    end else begin
      res = (upper ? CH_UA : CH_LA) + {4'b0, d} - 8'd10;
    end
    return res;
  endfunction

endpackage

### hw/rtl/icf_ctrl.sv
module icf_ctrl
  import icf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  icf_sts_t sts,
  output icf_cmd_t cmd
);

  icf_state_t state_r;
  icf_state_t state_nxt;
  icf_state_t seg_next;
  logic       seg_empty;
  logic       seg_single;
  icf_src_t   seg_src;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Properties of the output segment that the current state emits.
  always_comb begin
    seg_empty  = 1'b1;
    seg_single = 1'b0;
    seg_next   = ST_IDLE;
    seg_src    = SRC_LEAD;
    case (state_r)
      ST_LEAD: begin
        seg_empty = sts.lead_zero;
        seg_next  = ST_SIGN;
        seg_src   = SRC_LEAD;
      end
      ST_SIGN: begin
        seg_empty  = !sts.has_sign;
        seg_single = 1'b1;
        seg_next   = ST_PFX0;
        seg_src    = SRC_SIGN;
      end
      ST_PFX0: begin
        seg_empty  = (sts.pfx_len == 2'd0);
        seg_single = 1'b1;
        seg_next   = ST_PFX1;
        seg_src    = SRC_PFX0;
      end
      ST_PFX1: begin
        seg_empty  = (sts.pfx_len != 2'd2);
        seg_single = 1'b1;
        seg_next   = ST_ZPAD;
        seg_src    = SRC_PFX1;
      end
      ST_ZPAD: begin
        seg_empty = sts.zpad_zero;
        seg_next  = ST_PZERO;
        seg_src   = SRC_ZPAD;
      end
      ST_PZERO: begin
        seg_empty = sts.zcnt_zero;
        seg_next  = ST_DIG;
        seg_src   = SRC_PZERO;
      end
      ST_DIG: begin
        seg_empty = sts.nd_zero;
        seg_next  = ST_TRAIL;
        seg_src   = SRC_DIG;
      end
      ST_TRAIL: begin
        seg_empty = sts.trail_zero;
        seg_next  = ST_IDLE;
        seg_src   = SRC_TRAIL;
      end
      default: begin
        seg_empty = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        priority if (sts.skip_digits) begin
          state_nxt = ST_LAYOUT;
        end else if (!sts.is_dec || sts.conv_last) begin
          state_nxt = ST_NORM;
        end else begin
          state_nxt = ST_CONV;
        end
      end
      ST_NORM: begin
        if (sts.norm_done) begin
          state_nxt = ST_LAYOUT;
        end
      end
      ST_LAYOUT: begin
        state_nxt = ST_LEAD;
      end
      default: begin
        priority if (seg_empty) begin
          state_nxt = seg_next;
        end else if (sts.out_free) begin
          priority if (sts.remain_last) begin
            state_nxt = ST_IDLE;
          end else if (seg_single) begin
            state_nxt = seg_next;
          end else begin
            state_nxt = state_r;
          end
        end else begin
          state_nxt = state_r;
        end
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    cmd.src  = seg_src;
    in_stall = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE:   cmd.load      = in_valid;
      ST_CONV:   cmd.conv_step = sts.is_dec && !sts.skip_digits;
      ST_NORM:   cmd.norm_step = !sts.norm_done;
      ST_LAYOUT: cmd.layout    = 1'b1;
      default:   cmd.emit      = !seg_empty && sts.out_free;
    endcase
  end

endmodule

### hw/rtl/icf_datapath.sv
module icf_datapath
  import icf_pkg::*;
#(
  parameter int POINTER_DIGITS = POINTER_DIGITS_DEF,
  parameter int MAX_FIELD      = MAX_FIELD_DEF
)
(
  input  logic                clk,
  input  logic                rst_n,
  input  icf_cmd_t            cmd,
  output icf_sts_t            sts,
  input  logic [2:0]          in_conversion_kind,
  input  logic [1:0]          in_length_code,
  input  logic [4:0]          in_flag_bits,
  input  logic                in_width_given,
  input  logic [FIELD_W-1:0]  in_min_width,
  input  logic [PREC_W-1:0]   in_min_digits,
  input  logic [ARG_W-1:0]    in_arg_value,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CHAR_W-1:0]   out_char_out,
  output logic                out_last_char
);

  localparam int WW       = $clog2(MAX_FIELD + 1);
  localparam int PTR_BITS = POINTER_DIGITS * 4;
  localparam logic [ARG_W-1:0] PTR_MASK = ~({ARG_W{1'b1}} << PTR_BITS);

  icf_kind_t           kind_r, kind_nxt;
  logic                left_r, left_nxt;
  logic                zero_r, zero_nxt;
  logic                has_sign_r, has_sign_nxt;
  logic [CHAR_W-1:0]   sign_ch_r, sign_ch_nxt;
  logic [1:0]          pfx_len_r, pfx_len_nxt;
  logic [WW-1:0]       width_r, width_nxt;
  logic [PREC_W-1:0]   prec_r, prec_nxt;
  logic [ARG_W-1:0]    mag_r, mag_nxt;
  logic [CONV_W-1:0]   conv_cnt_r, conv_cnt_nxt;
  logic [DIG_W-1:0]    dig_r, dig_nxt;
  logic [ND_W-1:0]     nd_r, nd_nxt;
  logic [WW-1:0]       lead_r, lead_nxt;
  logic [WW-1:0]       zpad_r, zpad_nxt;
  logic [WW-1:0]       trail_r, trail_nxt;
  logic [PREC_W-1:0]   zcnt_r, zcnt_nxt;
  logic [REMAIN_W-1:0] remain_r, remain_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]   out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;

  icf_kind_t           in_kind;
  logic [ARG_W-1:0]    ext_val;
  logic [ARG_W-1:0]    mag_val;
  logic                is_neg;
  logic [ARG_W+1:0]    oct_src;
  logic [DIG_W-1:0]    oct_dig;
  logic [FIELD_W:0]    fw_ext;
  logic [FIELD_W:0]    fw_sat;
  logic                in_left;
  logic [BCD_W-1:0]    bcd_adj;
  logic [PREC_W-1:0]   dlen;
  logic [SIZE_W-1:0]   size;
  logic [WW-1:0]       pad;
  logic [TOTAL_W-1:0]  total;
  logic                upper;
  logic [CHAR_W-1:0]   emit_ch;

  assign in_kind = icf_kind_t'(in_conversion_kind);
  assign upper   = (kind_r == KIND_UHEX);

  // Argument interpretation at transfer: length cut, sign extension, pointer mask, negation.
  always_comb begin
    case (icf_len_t'(in_length_code))
      LEN_LONG:  ext_val = in_arg_value;
      LEN_SHORT: ext_val = (in_kind == KIND_DEC) ?
                           {{(ARG_W-16){in_arg_value[15]}}, in_arg_value[15:0]} :
                           {{(ARG_W-16){1'b0}}, in_arg_value[15:0]};
      default:   ext_val = (in_kind == KIND_DEC) ?
                           {{(ARG_W-32){in_arg_value[31]}}, in_arg_value[31:0]} :
                           {{(ARG_W-32){1'b0}}, in_arg_value[31:0]};
    endcase
    if (in_kind == KIND_PTR) begin
      ext_val = in_arg_value & PTR_MASK;
    end
    is_neg  = (in_kind == KIND_DEC) && ext_val[ARG_W-1];
    mag_val = is_neg ? (~ext_val + 64'd1) : ext_val;
    oct_src = {2'b00, mag_val};
    for (int i = 0; i < OCT_DIGITS; i++) begin
      oct_dig[4*i +: 4] = {1'b0, oct_src[3*i +: 3]};
    end
    fw_ext  = {1'b0, in_min_width};
    fw_sat  = (fw_ext > (FIELD_W+1)'(MAX_FIELD)) ? (FIELD_W+1)'(MAX_FIELD) : fw_ext;
    in_left = in_flag_bits[FLAG_LEFT];
  end

  // One double-dabble step on the BCD part of the digit store.
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (dig_r[DIG_W-BCD_W+4*i +: 4] >= 4'd5) ?
                          dig_r[DIG_W-BCD_W+4*i +: 4] + 4'd3 :
                          dig_r[DIG_W-BCD_W+4*i +: 4];
    end
  end

  // Field layout once the digit count is known.
  always_comb begin
    dlen  = ((PREC_W)'(nd_r) > prec_r) ? (PREC_W)'(nd_r) : prec_r;
    size  = SIZE_W'(width_r) - SIZE_W'(has_sign_r) - SIZE_W'(pfx_len_r) - SIZE_W'(dlen);
    pad   = size[SIZE_W-1] ? '0 : size[WW-1:0];
    total = TOTAL_W'(pad) + TOTAL_W'(has_sign_r) + TOTAL_W'(pfx_len_r) + TOTAL_W'(dlen);
  end

  always_comb begin
    unique case (cmd.src)
      SRC_LEAD, SRC_TRAIL:           emit_ch = CH_SPACE;
      SRC_SIGN:                      emit_ch = sign_ch_r;
      SRC_PFX0, SRC_ZPAD, SRC_PZERO: emit_ch = CH_ZERO;
      SRC_PFX1:                      emit_ch = upper ? CH_UX : CH_LX;
      SRC_DIG:                       emit_ch = digit_char(dig_r[DIG_W-1 -: 4], upper);
    endcase
  end

  always_comb begin
    kind_nxt      = kind_r;
    left_nxt      = left_r;
    zero_nxt      = zero_r;
    has_sign_nxt  = has_sign_r;
    sign_ch_nxt   = sign_ch_r;
    pfx_len_nxt   = pfx_len_r;
    width_nxt     = width_r;
    prec_nxt      = prec_r;
    mag_nxt       = mag_r;
    conv_cnt_nxt  = conv_cnt_r;
    dig_nxt       = dig_r;
    nd_nxt        = nd_r;
    lead_nxt      = lead_r;
    zpad_nxt      = zpad_r;
    trail_nxt     = trail_r;
    zcnt_nxt      = zcnt_r;
    remain_nxt    = remain_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    if (cmd.load) begin
      kind_nxt     = in_kind;
      left_nxt     = in_left;
      zero_nxt     = in_flag_bits[FLAG_ZERO] && !in_left;
      width_nxt    = in_width_given ? fw_sat[WW-1:0] : '0;
      prec_nxt     = (in_min_digits > PREC_W'(MAX_PREC)) ? PREC_W'(MAX_PREC) : in_min_digits;
      mag_nxt      = mag_val;
      conv_cnt_nxt = '1;
      has_sign_nxt = 1'b0;
      sign_ch_nxt  = CH_SPACE;
      pfx_len_nxt  = 2'd0;
      dig_nxt      = '0;
      nd_nxt       = ND_W'(DEC_DIGITS);
      unique case (in_kind)
        KIND_DEC: begin
          priority if (is_neg) begin
            has_sign_nxt = 1'b1;
            sign_ch_nxt  = CH_MINUS;
          end else if (in_flag_bits[FLAG_PLUS]) begin
            has_sign_nxt = 1'b1;
            sign_ch_nxt  = CH_PLUS;
          end else if (in_flag_bits[FLAG_SPACE]) begin
            has_sign_nxt = 1'b1;
            sign_ch_nxt  = CH_SPACE;
          end else begin
            has_sign_nxt = 1'b0;
          end
        end
        KIND_UNS: begin
          has_sign_nxt = 1'b0;
        end
        KIND_OCT: begin
          pfx_len_nxt = in_flag_bits[FLAG_ALT] ? 2'd1 : 2'd0;
          dig_nxt     = oct_dig;
          nd_nxt      = ND_W'(OCT_DIGITS);
        end
        KIND_HEX, KIND_UHEX, KIND_PTR: begin
          pfx_len_nxt = in_flag_bits[FLAG_ALT] ? 2'd2 : 2'd0;
          dig_nxt     = {mag_val, {(DIG_W-ARG_W){1'b0}}};
          nd_nxt      = ND_W'(HEX_DIGITS);
          if (in_kind == KIND_PTR && !in_width_given) begin
            width_nxt = WW'(POINTER_DIGITS);
            zero_nxt  = !in_left;
          end
        end
        KIND_CHR: begin
          has_sign_nxt = 1'b1;
          sign_ch_nxt  = in_arg_value[CHAR_W-1:0];
          zero_nxt     = 1'b0;
          prec_nxt     = '0;
          nd_nxt       = '0;
        end
        KIND_PCT: begin
          has_sign_nxt = 1'b1;
          sign_ch_nxt  = CH_PCT;
          zero_nxt     = 1'b0;
          width_nxt    = '0;
          prec_nxt     = '0;
          nd_nxt       = '0;
        end
      endcase
    end

    if (cmd.conv_step) begin
      dig_nxt      = {bcd_adj[BCD_W-2:0], mag_r[ARG_W-1], {(DIG_W-BCD_W){1'b0}}};
      mag_nxt      = {mag_r[ARG_W-2:0], 1'b0};
      conv_cnt_nxt = conv_cnt_r - 1'b1;
    end

    // Leading zero digits are shifted out so the top slot holds the first digit.
    if (cmd.norm_step) begin
      dig_nxt = {dig_r[DIG_W-5:0], 4'd0};
      nd_nxt  = nd_r - 1'b1;
    end

    if (cmd.layout) begin
      lead_nxt   = (!left_r && !zero_r) ? pad : '0;
      zpad_nxt   = (!left_r && zero_r) ? pad : '0;
      trail_nxt  = left_r ? pad : '0;
      zcnt_nxt   = dlen - PREC_W'(nd_r);
      remain_nxt = (total > TOTAL_W'(OUT_LIMIT)) ? REMAIN_W'(OUT_LIMIT) :
                   total[REMAIN_W-1:0];
    end

    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = emit_ch;
      out_last_nxt  = (remain_r == REMAIN_W'(1));
      remain_nxt    = remain_r - 1'b1;
      case (cmd.src)
        SRC_LEAD:  lead_nxt  = lead_r - 1'b1;
        SRC_ZPAD:  zpad_nxt  = zpad_r - 1'b1;
        SRC_PZERO: zcnt_nxt  = zcnt_r - 1'b1;
        SRC_TRAIL: trail_nxt = trail_r - 1'b1;
        SRC_DIG: begin
          dig_nxt = {dig_r[DIG_W-5:0], 4'd0};
          nd_nxt  = nd_r - 1'b1;
        end
        default: begin
          nd_nxt = nd_r;
        end
      endcase
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    left_r     <= left_nxt;
    zero_r     <= zero_nxt;
    has_sign_r <= has_sign_nxt;
    sign_ch_r  <= sign_ch_nxt;
    pfx_len_r  <= pfx_len_nxt;
    width_r    <= width_nxt;
    prec_r     <= prec_nxt;
    mag_r      <= mag_nxt;
    conv_cnt_r <= conv_cnt_nxt;
    dig_r      <= dig_nxt;
    nd_r       <= nd_nxt;
    lead_r     <= lead_nxt;
    zpad_r     <= zpad_nxt;
    trail_r    <= trail_nxt;
    zcnt_r     <= zcnt_nxt;
    remain_r   <= remain_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    sts.is_dec      = (kind_r == KIND_DEC) || (kind_r == KIND_UNS);
    sts.skip_digits = (kind_r == KIND_CHR) || (kind_r == KIND_PCT);
    sts.conv_last   = (conv_cnt_r == '0);
    sts.norm_done   = (dig_r[DIG_W-1 -: 4] != 4'd0) || (nd_r == ND_W'(1));
    sts.lead_zero   = (lead_r == '0);
    sts.has_sign    = has_sign_r;
    sts.pfx_len     = pfx_len_r;
    sts.zpad_zero   = (zpad_r == '0);
    sts.zcnt_zero   = (zcnt_r == '0);
    sts.nd_zero     = (nd_r == '0);
    sts.trail_zero  = (trail_r == '0);
    sts.remain_last = (remain_r == REMAIN_W'(1));
    sts.out_free    = !out_valid_r || !out_stall;
  end

  assign out_valid     = out_valid_r;
  assign out_char_out  = out_char_r;
  assign out_last_char = out_last_r;

endmodule

### hw/rtl/integer_conversion_formatter_top.sv
// Flow: bit-serial BCD conversion for decimal kinds, then normalisation that drops leading
// zero digits, a layout step, then each output segment in order, empty segments skipped.
// One conversion at a time; within a segment, characters go out one per cycle while out_stall is low.
// Reset: synchronous active-low rst_n sends the controller to idle and clears out_valid.
module integer_conversion_formatter_top
  import icf_pkg::*;
#(
  parameter int POINTER_DIGITS = POINTER_DIGITS_DEF,
  parameter int MAX_FIELD      = MAX_FIELD_DEF
)
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_conversion_kind,
  input  logic [1:0]         in_length_code,
  input  logic [4:0]         in_flag_bits,
  input  logic               in_width_given,
  input  logic [FIELD_W-1:0] in_min_width,
  input  logic [PREC_W-1:0]  in_min_digits,
  input  logic [ARG_W-1:0]   in_arg_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [CHAR_W-1:0]  out_char_out,
  output logic               out_last_char
);

  icf_cmd_t cmd;
  icf_sts_t sts;

  icf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  icf_datapath #(
    .POINTER_DIGITS (POINTER_DIGITS),
    .MAX_FIELD      (MAX_FIELD)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_conversion_kind (in_conversion_kind),
    .in_length_code     (in_length_code),
    .in_flag_bits       (in_flag_bits),
    .in_width_given     (in_width_given),
    .in_min_width       (in_min_width),
    .in_min_digits      (in_min_digits),
    .in_arg_value       (in_arg_value),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_char_out       (out_char_out),
    .out_last_char      (out_last_char)
  );

endmodule
